@@ design/i2cm_pkg.sv @@
// i2cm_pkg: shared types and constants of the tick-paced I2C bit-level master.
// No dependencies; imported by the top, front and engine modules (not the queue).
`timescale 1ns / 1ps

package i2cm_pkg;

	// Command codes carried by the opcode field
	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_STOP     = 3'd1,
		OP_WRITE    = 3'd2,
		OP_READ     = 3'd3,
		OP_WAIT_ACK = 3'd4
	} op_t;

	// Acknowledge choice after a read
	localparam logic [1:0] ACK_SEND_NACK = 2'd0;
	localparam logic [1:0] ACK_SEND_ACK  = 2'd1;

	// Configuration register indexes
	localparam logic CFG_TICKS_PER_US = 1'b0;
	localparam logic CFG_ACK_TIMEOUT  = 1'b1;

	localparam logic [7:0] TICKS_PER_US_RST = 8'd50;
	localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

	// Delay counter: up to 4 us at 255 ticks per us
	localparam int DLY_W = 10;

	// Delay lengths as shift amounts of ticks_per_microsecond
	localparam logic [1:0] US_1 = 2'd0;
	localparam logic [1:0] US_2 = 2'd1;
	localparam logic [1:0] US_4 = 2'd2;

	// One classified tick travelling from front to back
	typedef struct packed {
		logic       go;
		op_t        op;
		logic [7:0] data;
		logic [1:0] mode;
		logic       sda;
	} tick_t;

	// Configuration seen by the bit engine
	typedef struct packed {
		logic [7:0] ticks_per_us;
		logic [7:0] ack_timeout;
	} cfg_t;

	// Pin and status snapshot after one tick
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drive;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       nack;
	} res_t;

	// Delay length in ticks; a zero product lasts one tick
	function automatic logic [DLY_W-1:0] wait_len(logic [7:0] tpu, logic [1:0] sh);
		logic [DLY_W-1:0] len;
		len = {{(DLY_W-8){1'b0}}, tpu} << sh;
		if (len == '0) begin
			len = {{(DLY_W-1){1'b0}}, 1'b1};
		end
		return len;
	endfunction

endpackage

@@ design/i2c_bit_level_master.sv @@
// Tick-paced I2C bit-level master: one result transaction per input tick transaction.
// An accepted tick is queued, stepped, and registered as a result (empty low).
// Throughput: one tick per cycle while each result is popped; a held result stalls.
// Reset (arst_n low, asynchronous): queue and result slot empty, bus idle with SCL and SDA high
// and driven, registers back to 50 ticks per us and an ACK timeout of 250.
`timescale 1ns / 1ps

module i2c_bit_level_master
	import i2cm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       cmd_valid,
	input  logic [2:0] opcode,
	input  logic [7:0] data_byte,
	input  logic [1:0] ack_mode,
	input  logic       sda_in,
	output logic       empty,
	input  logic       pop,
	output logic       scl_level,
	output logic       sda_level,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       nack_error,
	input  logic       cfg_we,
	input  logic       cfg_addr,
	input  logic [7:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  q_wr, q_rd, q_not_empty;
	tick_t q_wdata, q_rdata;
	logic  res_valid;
	res_t  res;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_us <= TICKS_PER_US_RST;
			cfg_q.ack_timeout  <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_wdata;
				CFG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	i2cm_front u_front (
		.push      (push),
		.q_full    (full),
		.cmd_valid (cmd_valid),
		.opcode    (opcode),
		.data_byte (data_byte),
		.ack_mode  (ack_mode),
		.sda_in    (sda_in),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata)
	);

	i2cm_fifo #(
		.WIDTH ($bits(tick_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (q_wr),
		.wdata     (q_wdata),
		.rd        (q_rd),
		.rdata     (q_rdata),
		.full      (full),
		.not_empty (q_not_empty)
	);

	i2cm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tick_valid (q_not_empty),
		.tick       (q_rdata),
		.take       (q_rd),
		.pop        (pop),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Drive result ports from the engine snapshot
	assign empty      = !res_valid;
	assign scl_level  = res.scl;
	assign sda_level  = res.sda;
	assign sda_drive  = res.drive;
	assign busy_res   = res.busy;
	assign done_res   = res.done;
	assign read_data  = res.rdata;
	assign nack_error = res.nack;

`ifndef SYNTHESIS
	// A completion pulse always leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> !busy_res)
		else $error("done pulse while still busy");

	// A stepped tick always presents a result next cycle
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> !empty)
		else $error("engine step produced no result");

	// The engine never steps from an empty queue
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_not_empty)
		else $error("queue read while empty");

	// A result held back by the consumer keeps its pins
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(scl_level) && $stable(sda_drive) && !empty))
		else $error("result changed while stalled");
`endif

endmodule

@@ design/i2cm_front.sv @@
// i2cm_front: accepts ticks from the input queue port and classifies the command.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front
	import i2cm_pkg::*;
(
	input  logic       push,
	input  logic       q_full,
	input  logic       cmd_valid,
	input  logic [2:0] opcode,
	input  logic [7:0] data_byte,
	input  logic [1:0] ack_mode,
	input  logic       sda_in,
	output logic       q_wr,
	output tick_t      q_wdata
);

	logic known_op;

	// Flag opcodes the engine acts on; others count as no command
	always_comb begin
		unique case (opcode)
			OP_START, OP_STOP, OP_WRITE, OP_READ, OP_WAIT_ACK: known_op = 1'b1;
			default: known_op = 1'b0;
		endcase
	end

	// Build the tick and write it into the queue on acceptance
	always_comb begin
		q_wr          = push && !q_full;
		q_wdata.go    = cmd_valid && known_op;
		q_wdata.op    = op_t'(opcode);
		q_wdata.data  = data_byte;
		q_wdata.mode  = ack_mode;
		q_wdata.sda   = sda_in;
	end

endmodule

@@ design/i2cm_fifo.sv @@
// i2cm_fifo: small register queue between front and bit engine.
// No package dependencies.
`timescale 1ns / 1ps

module i2cm_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/i2cm_engine.sv @@
// i2cm_engine: bit engine; steps the I2C sequencer one tick per cycle unless a
// result is held, and holds the pin and status snapshot. Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_engine
	import i2cm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  tick_valid,
	input  tick_t tick,
	output logic  take,
	input  logic  pop,
	output logic  res_valid,
	output res_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_START1, PH_START2, PH_STOP1, PH_STOP2,
		PH_WA1, PH_WA2, PH_WAPOLL, PH_WRSET, PH_WRHIGH, PH_WRLOW,
		PH_RDLOW, PH_RDHIGH, PH_AKSET, PH_AKHIGH
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [3:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic [DLY_W-1:0] dly_q, dly_d;
	logic [7:0]       tcnt_q, tcnt_d;
	logic             scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
	logic [1:0]       ack_q, ack_d;
	logic             err_q, err_d;
	logic [7:0]       rdata_q, rdata_d;
	logic             done_q, done_d;
	logic             vld_q;

	// Step only when the result slot is free or being read
	assign take      = tick_valid && (!vld_q || pop);
	assign res_valid = vld_q;

	always_comb begin
		res.scl   = scl_q;
		res.sda   = sda_q;
		res.drive = drv_q;
		res.busy  = (phase_q != PH_IDLE);
		res.done  = done_q;
		res.rdata = rdata_q;
		res.nack  = err_q;
	end

	// Next state of the sequencer for one tick
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		dly_d   = dly_q;
		tcnt_d  = tcnt_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		drv_d   = drv_q;
		ack_d   = ack_q;
		err_d   = err_q;
		rdata_d = rdata_q;
		done_d  = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (tick.go) begin
				unique case (tick.op)
					OP_START: begin
						drv_d   = 1'b1;
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						dly_d   = wait_len(cfg.ticks_per_us, US_4);
						phase_d = PH_START1;
					end
					OP_STOP: begin
						drv_d   = 1'b1;
						scl_d   = 1'b0;
						sda_d   = 1'b0;
						dly_d   = wait_len(cfg.ticks_per_us, US_4);
						phase_d = PH_STOP1;
					end
					OP_WRITE: begin
						drv_d   = 1'b1;
						scl_d   = 1'b0;
						sda_d   = tick.data[7];
						shift_d = {tick.data[6:0], 1'b0};
						bit_d   = 4'd1;
						dly_d   = wait_len(cfg.ticks_per_us, US_2);
						phase_d = PH_WRSET;
					end
					OP_READ: begin
						drv_d   = 1'b0;
						scl_d   = 1'b0;
						shift_d = '0;
						bit_d   = '0;
						ack_d   = tick.mode;
						dly_d   = wait_len(cfg.ticks_per_us, US_2);
						phase_d = PH_RDLOW;
					end
					OP_WAIT_ACK: begin
						drv_d   = 1'b0;
						sda_d   = 1'b1;
						tcnt_d  = '0;
						err_d   = 1'b0;
						dly_d   = wait_len(cfg.ticks_per_us, US_1);
						phase_d = PH_WA1;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end else if ((phase_q == PH_WAPOLL) || (phase_q == PH_WA2 && dly_q <= DLY_W'(1))) begin
			// Poll for the slave's acknowledge
			if (!tick.sda) begin
				scl_d   = 1'b0;
				phase_d = PH_IDLE;
				done_d  = 1'b1;
			end else if (tcnt_q >= cfg.ack_timeout) begin
				err_d   = 1'b1;
				drv_d   = 1'b1;
				scl_d   = 1'b0;
				sda_d   = 1'b0;
				dly_d   = wait_len(cfg.ticks_per_us, US_4);
				phase_d = PH_STOP1;
			end else begin
				tcnt_d  = tcnt_q + 1'b1;
				phase_d = PH_WAPOLL;
			end
		end else if (dly_q > DLY_W'(1)) begin
			dly_d = dly_q - 1'b1;
		end else begin
			// Delay ran out: perform the next step
			unique case (phase_q)
				PH_START1: begin
					sda_d   = 1'b0;
					dly_d   = wait_len(cfg.ticks_per_us, US_4);
					phase_d = PH_START2;
				end
				PH_START2: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_STOP1: begin
					scl_d   = 1'b1;
					dly_d   = wait_len(cfg.ticks_per_us, US_4);
					phase_d = PH_STOP2;
				end
				PH_STOP2: begin
					sda_d   = 1'b1;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_WA1: begin
					scl_d   = 1'b1;
					dly_d   = wait_len(cfg.ticks_per_us, US_1);
					phase_d = PH_WA2;
				end
				PH_WRSET: begin
					scl_d   = 1'b1;
					dly_d   = wait_len(cfg.ticks_per_us, US_2);
					phase_d = PH_WRHIGH;
				end
				PH_WRHIGH: begin
					scl_d   = 1'b0;
					dly_d   = wait_len(cfg.ticks_per_us, US_2);
					phase_d = PH_WRLOW;
				end
				PH_WRLOW: begin
					if (bit_q >= 4'd8) begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end else begin
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						bit_d   = bit_q + 1'b1;
						dly_d   = wait_len(cfg.ticks_per_us, US_2);
						phase_d = PH_WRSET;
					end
				end
				PH_RDLOW: begin
					scl_d   = 1'b1;
					shift_d = {shift_q[6:0], tick.sda};
					bit_d   = bit_q + 1'b1;
					dly_d   = wait_len(cfg.ticks_per_us, US_1);
					phase_d = PH_RDHIGH;
				end
				PH_RDHIGH: begin
					if (bit_q >= 4'd8) begin
						rdata_d = shift_q;
						if (ack_q == ACK_SEND_NACK || ack_q == ACK_SEND_ACK) begin
							scl_d   = 1'b0;
							drv_d   = 1'b1;
							sda_d   = (ack_q == ACK_SEND_NACK);
							dly_d   = wait_len(cfg.ticks_per_us, US_2);
							phase_d = PH_AKSET;
						end else begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end
					end else begin
						scl_d   = 1'b0;
						dly_d   = wait_len(cfg.ticks_per_us, US_2);
						phase_d = PH_RDLOW;
					end
				end
				PH_AKSET: begin
					scl_d   = 1'b1;
					dly_d   = wait_len(cfg.ticks_per_us, US_2);
					phase_d = PH_AKHIGH;
				end
				PH_AKHIGH: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Hold sequencer state and the result snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			dly_q   <= '0;
			tcnt_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b1;
			ack_q   <= '0;
			err_q   <= 1'b0;
			rdata_q <= '0;
			done_q  <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				dly_q   <= dly_d;
				tcnt_q  <= tcnt_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				drv_q   <= drv_d;
				ack_q   <= ack_d;
				err_q   <= err_d;
				rdata_q <= rdata_d;
				done_q  <= done_d;
				vld_q   <= 1'b1;
			end else if (pop) begin
				vld_q   <= 1'b0;
			end
		end
	end

endmodule

@@ tb/tb_i2c_bit_level_master.sv @@
// tb_i2c_bit_level_master: self-checking bench for the tick-paced I2C bit-level master.
// Depends on i2cm_pkg and i2c_bit_level_master; a directed table and random I2C
// traffic are checked tick by tick against a behavioral model of the bus engine.
`timescale 1ns / 1ps

module tb_i2c_bit_level_master;
	import i2cm_pkg::*;

	// Opcodes outside the command set, and the ack choices the package leaves unnamed
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;
	localparam logic [1:0] ACK_SEND_NONE = 2'd2;
	localparam logic [1:0] ACK_MODE_SPARE = 2'd3;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int PIPE_SLACK = 4;

	typedef enum logic [3:0] {
		BUS_IDLE, BUS_START_SDA, BUS_START_SCL, BUS_STOP_SCL, BUS_STOP_SDA,
		BUS_ACK_RISE, BUS_ACK_SETTLE, BUS_ACK_POLL, BUS_WR_SETUP, BUS_WR_HIGH,
		BUS_WR_LOW, BUS_RD_LOW, BUS_RD_HIGH, BUS_ACKOUT_SETUP, BUS_ACKOUT_HIGH
	} bus_phase_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] op;
		logic [7:0] data;
		logic [1:0] mode;
		logic       sda;
	} cmd_tick_t;

	typedef struct packed {
		logic       is_cfg;
		logic [7:0] tpu;
		logic [7:0] tmo;
		cmd_tick_t  cmd;
		logic       typed;
		res_t       want;
	} dir_row_t;

	localparam res_t RES_RESET_IDLE = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b0,
		done: 1'b0, rdata: 8'h00, nack: 1'b0};
	localparam res_t RES_START_TAKEN = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b1,
		done: 1'b0, rdata: 8'h00, nack: 1'b0};
	localparam res_t RES_NACK_IDLE = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b0,
		done: 1'b0, rdata: 8'h00, nack: 1'b1};

	// Each command row is repeated on every busy tick until the engine is idle again
	localparam int DIR_ROWS_N = 25;
	localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
		'{1'b0, 8'd0, 8'd0, '{1'b0, OP_START, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b1, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_RSVD_5, 8'hFF, ACK_SEND_ACK, 1'b0}, 1'b1, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_RSVD_6, 8'h00, ACK_SEND_NONE, 1'b1}, 1'b1, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_RSVD_7, 8'h5A, ACK_MODE_SPARE, 1'b0}, 1'b1, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WAIT_ACK, 8'h00, ACK_SEND_NACK, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b1, 8'd1, 8'd2, '{1'b0, OP_START, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_START, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b1, RES_START_TAKEN},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WAIT_ACK, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b0, OP_START, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b1, RES_NACK_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_START, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WRITE, 8'hFF, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WAIT_ACK, 8'h00, ACK_SEND_NACK, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WRITE, 8'h00, ACK_SEND_ACK, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WAIT_ACK, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_START, 8'h00, ACK_SEND_NACK, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WRITE, 8'hA5, ACK_SEND_NACK, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_READ, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_READ, 8'hFF, ACK_SEND_ACK, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_READ, 8'h00, ACK_SEND_NONE, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_READ, 8'h00, ACK_MODE_SPARE, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_STOP, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b1, 8'd0, 8'd0, '{1'b0, OP_START, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_WAIT_ACK, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_START, 8'h00, ACK_SEND_NACK, 1'b0}, 1'b0, RES_RESET_IDLE},
		'{1'b0, 8'd0, 8'd0, '{1'b1, OP_STOP, 8'h00, ACK_SEND_NACK, 1'b1}, 1'b0, RES_RESET_IDLE}
	};

	// Random phases: register settings and tick budget of each
	localparam int RND_PHASES = 6;
	localparam logic [7:0] RND_TPU [0:RND_PHASES-1] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd1, 8'd0};
	localparam logic [7:0] RND_TMO [0:RND_PHASES-1] = '{8'd1, 8'd0, 8'd40, 8'd6, 8'd12, 8'd3};
	localparam int RND_TICKS [0:RND_PHASES-1] = '{40, 50, 35, 30, 25, 35};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       cmd_valid = 1'b0;
	logic [2:0] opcode = OP_START;
	logic [7:0] data_byte = 8'h00;
	logic [1:0] ack_mode = ACK_SEND_NACK;
	logic       sda_in = 1'b1;
	logic       empty;
	logic       pop = 1'b0;
	logic       scl_level, sda_level, sda_drive, busy_res, done_res, nack_error;
	logic [7:0] read_data;
	logic       cfg_we = 1'b0;
	logic       cfg_addr = CFG_TICKS_PER_US;
	logic [7:0] cfg_wdata = 8'h00;

	// Bus engine model state
	bus_phase_t bus_ph;
	logic [3:0]  bit_cnt;
	logic [7:0]  shreg;
	logic [15:0] dly_cnt;
	logic [7:0]  poll_cnt;
	logic        m_scl, m_sda, m_drive;
	logic [1:0]  ack_sel;
	logic        m_nack;
	logic [7:0]  m_rdata;
	logic        m_done;
	logic [7:0]  tpu_r, tmo_r;

	res_t pin_snapshots_q[$];
	logic [2:0] op_plan_q[$];
	bit   slave_nak;
	bit   calm = 1'b0;
	bit   hold_req = 1'b0;
	int   mismatches = 0;
	int   tick_count = 0;
	int   cmd_count = 0;
	int   timeout_count = 0;
	int   read_count = 0;
	int   setting_count = 0;
	int   stall_cycles = 0;

	i2c_bit_level_master uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.cmd_valid(cmd_valid), .opcode(opcode), .data_byte(data_byte),
		.ack_mode(ack_mode), .sda_in(sda_in), .empty(empty), .pop(pop),
		.scl_level(scl_level), .sda_level(sda_level), .sda_drive(sda_drive),
		.busy_res(busy_res), .done_res(done_res), .read_data(read_data),
		.nack_error(nack_error), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Hold reset at the start, then release it
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Load a delay of us microseconds; a zero product lasts one tick
	task automatic arm_delay(input bus_phase_t nxt, input int unsigned us);
		int unsigned len;
		len = us * tpu_r;
		if (len == 0) begin
			len = 1;
		end
		dly_cnt = len[15:0];
		bus_ph = nxt;
	endtask

	task automatic finish_cmd();
		bus_ph = BUS_IDLE;
		m_done = 1'b1;
	endtask

	task automatic begin_stop();
		m_drive = 1'b1;
		m_scl = 1'b0;
		m_sda = 1'b0;
		arm_delay(BUS_STOP_SCL, 4);
	endtask

	task automatic shift_out_bit();
		m_sda = shreg[7];
		shreg = shreg << 1;
		bit_cnt = bit_cnt + 4'd1;
		arm_delay(BUS_WR_SETUP, 2);
	endtask

	// Slave ACK: low ends the wait, a timeout sends a stop and flags NACK
	task automatic poll_slave_ack(input logic sda);
		if (sda == 1'b0) begin
			m_scl = 1'b0;
			finish_cmd();
		end else if (poll_cnt >= tmo_r) begin
			m_nack = 1'b1;
			timeout_count++;
			begin_stop();
		end else begin
			poll_cnt = poll_cnt + 8'd1;
			bus_ph = BUS_ACK_POLL;
		end
	endtask

	task automatic take_cmd(input cmd_tick_t t);
		case (t.op)
			OP_START: begin
				m_drive = 1'b1;
				m_sda = 1'b1;
				m_scl = 1'b1;
				arm_delay(BUS_START_SDA, 4);
			end
			OP_STOP: begin
				begin_stop();
			end
			OP_WRITE: begin
				m_drive = 1'b1;
				m_scl = 1'b0;
				shreg = t.data;
				bit_cnt = '0;
				shift_out_bit();
			end
			OP_READ: begin
				m_drive = 1'b0;
				m_scl = 1'b0;
				shreg = '0;
				bit_cnt = '0;
				ack_sel = t.mode;
				arm_delay(BUS_RD_LOW, 2);
			end
			OP_WAIT_ACK: begin
				m_drive = 1'b0;
				m_sda = 1'b1;
				poll_cnt = '0;
				m_nack = 1'b0;
				arm_delay(BUS_ACK_RISE, 1);
			end
			default: begin
			end
		endcase
		if (bus_ph != BUS_IDLE) begin
			cmd_count++;
		end
	endtask

	// Advance the bus sequence when the current delay runs out
	task automatic delay_expired(input logic sda);
		case (bus_ph)
			BUS_START_SDA: begin
				m_sda = 1'b0;
				arm_delay(BUS_START_SCL, 4);
			end
			BUS_START_SCL: begin
				m_scl = 1'b0;
				finish_cmd();
			end
			BUS_STOP_SCL: begin
				m_scl = 1'b1;
				arm_delay(BUS_STOP_SDA, 4);
			end
			BUS_STOP_SDA: begin
				m_sda = 1'b1;
				finish_cmd();
			end
			BUS_ACK_RISE: begin
				m_scl = 1'b1;
				arm_delay(BUS_ACK_SETTLE, 1);
			end
			BUS_ACK_SETTLE: begin
				poll_slave_ack(sda);
			end
			BUS_WR_SETUP: begin
				m_scl = 1'b1;
				arm_delay(BUS_WR_HIGH, 2);
			end
			BUS_WR_HIGH: begin
				m_scl = 1'b0;
				arm_delay(BUS_WR_LOW, 2);
			end
			BUS_WR_LOW: begin
				if (bit_cnt >= 4'd8) begin
					finish_cmd();
				end else begin
					shift_out_bit();
				end
			end
			BUS_RD_LOW: begin
				m_scl = 1'b1;
				shreg = {shreg[6:0], sda};
				bit_cnt = bit_cnt + 4'd1;
				arm_delay(BUS_RD_HIGH, 1);
			end
			BUS_RD_HIGH: begin
				if (bit_cnt >= 4'd8) begin
					m_rdata = shreg;
					read_count++;
					if (ack_sel == ACK_SEND_NACK || ack_sel == ACK_SEND_ACK) begin
						m_scl = 1'b0;
						m_drive = 1'b1;
						m_sda = (ack_sel == ACK_SEND_NACK);
						arm_delay(BUS_ACKOUT_SETUP, 2);
					end else begin
						finish_cmd();
					end
				end else begin
					m_scl = 1'b0;
					arm_delay(BUS_RD_LOW, 2);
				end
			end
			BUS_ACKOUT_SETUP: begin
				m_scl = 1'b1;
				arm_delay(BUS_ACKOUT_HIGH, 2);
			end
			BUS_ACKOUT_HIGH: begin
				m_scl = 1'b0;
				finish_cmd();
			end
			default: begin
				bus_ph = BUS_IDLE;
			end
		endcase
	endtask

	// One tick of the bus engine; returns the pins and status after the tick
	task automatic advance_bus(input cmd_tick_t t, output res_t r);
		m_done = 1'b0;
		if (bus_ph == BUS_IDLE) begin
			if (t.valid) begin
				take_cmd(t);
			end
		end else if (bus_ph == BUS_ACK_POLL) begin
			poll_slave_ack(t.sda);
		end else if (dly_cnt > 16'd1) begin
			dly_cnt = dly_cnt - 16'd1;
		end else begin
			delay_expired(t.sda);
		end
		r.scl = m_scl;
		r.sda = m_sda;
		r.drive = m_drive;
		r.busy = (bus_ph != BUS_IDLE);
		r.done = m_done;
		r.rdata = m_rdata;
		r.nack = m_nack;
	endtask

	// Offer one tick, wait for its transaction, then queue the expected pins
	task automatic offer_tick(input cmd_tick_t t, input bit typed, input res_t want);
		res_t r;
		if (!calm && $urandom_range(0, 19) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		cmd_valid <= t.valid;
		opcode <= t.op;
		data_byte <= t.data;
		ack_mode <= t.mode;
		sda_in <= t.sda;
		do
			@(posedge clk);
		while (full);
		advance_bus(t, r);
		pin_snapshots_q.push_back(typed ? want : r);
		tick_count++;
	endtask

	// Random tick with no command; during an ACK wait the slave follows its plan
	task automatic quiet_tick(output cmd_tick_t t);
		t.valid = 1'b0;
		t.op = 3'($urandom);
		t.data = 8'($urandom);
		t.mode = 2'($urandom);
		t.sda = 1'($urandom);
		if (bus_ph == BUS_ACK_SETTLE || bus_ph == BUS_ACK_POLL || bus_ph == BUS_ACK_RISE) begin
			t.sda = slave_nak ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	endtask

	// Mostly a well-formed transfer: start, address, ACK, data or reads, stop
	task automatic plan_transfer();
		int n;
		if ($urandom_range(0, 99) < 85) begin
			op_plan_q.push_back(OP_START);
			op_plan_q.push_back(OP_WRITE);
			op_plan_q.push_back(OP_WAIT_ACK);
			n = $urandom_range(1, 3);
			repeat (n) begin
				if ($urandom_range(0, 1) == 0) begin
					op_plan_q.push_back(OP_WRITE);
					op_plan_q.push_back(OP_WAIT_ACK);
				end else begin
					op_plan_q.push_back(OP_READ);
				end
			end
			op_plan_q.push_back(OP_STOP);
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) op_plan_q.push_back(3'($urandom_range(0, 7)));
		end
	endtask

	task automatic pick_tick(output cmd_tick_t t);
		quiet_tick(t);
		if (bus_ph == BUS_IDLE) begin
			if ($urandom_range(0, 9) < 7) begin
				if (op_plan_q.size() == 0) begin
					plan_transfer();
				end
				t.valid = 1'b1;
				t.op = op_plan_q.pop_front();
				slave_nak = ($urandom_range(0, 3) == 0);
			end else begin
				t.valid = 1'($urandom_range(0, 1));
			end
		end else begin
			t.valid = 1'($urandom_range(0, 1));
		end
	endtask

	// Finish the bus command, drain the results, then write both registers
	task automatic program_regs(input logic [7:0] tpu, input logic [7:0] tmo);
		cmd_tick_t t;
		res_t unused;
		unused = RES_RESET_IDLE;
		while (bus_ph != BUS_IDLE) begin
			quiet_tick(t);
			offer_tick(t, 1'b0, unused);
		end
		push <= 1'b0;
		while (pin_snapshots_q.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_TICKS_PER_US;
		cfg_wdata <= tpu;
		@(posedge clk);
		cfg_addr <= CFG_ACK_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
		tpu_r = tpu;
		tmo_r = tmo;
		setting_count++;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result side: check each transaction, idle in bursts, hold off once on request
	initial begin
		res_t want;
		int gap_left;
		bit pop_next;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pin_snapshots_q.size() == 0) begin
					$error("result transaction with no expected result waiting");
					mismatches++;
				end else begin
					want = pin_snapshots_q.pop_front();
					check_field("scl_level", 32'(want.scl), 32'(scl_level));
					check_field("sda_level", 32'(want.sda), 32'(sda_level));
					check_field("sda_drive", 32'(want.drive), 32'(sda_drive));
					check_field("busy_res", 32'(want.busy), 32'(busy_res));
					check_field("done_res", 32'(want.done), 32'(done_res));
					check_field("read_data", 32'(want.rdata), 32'(read_data));
					check_field("nack_error", 32'(want.nack), 32'(nack_error));
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				gap_left = HOLD_OFF_CYCLES;
			end else if (gap_left == 0 && !calm && $urandom_range(0, 19) == 0) begin
				gap_left = $urandom_range(1, 13);
			end
			pop_next = (gap_left == 0) && arst_n;
			if (gap_left > 0) begin
				gap_left--;
			end
			pop <= pop_next;
		end
	end

	// Stop the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Stimulus: directed table, then random transfers over several register settings
	initial begin
		cmd_tick_t t;
		dir_row_t row;
		res_t unused;
		int n;
		unused = RES_RESET_IDLE;
		tpu_r = TICKS_PER_US_RST;
		tmo_r = ACK_TIMEOUT_RST;
		bus_ph = BUS_IDLE;
		bit_cnt = '0;
		shreg = '0;
		dly_cnt = '0;
		poll_cnt = '0;
		m_scl = 1'b1;
		m_sda = 1'b1;
		m_drive = 1'b1;
		ack_sel = ACK_SEND_NACK;
		m_nack = 1'b0;
		m_rdata = '0;
		m_done = 1'b0;
		slave_nak = 1'b0;
		do
			@(posedge clk);
		while (!arst_n);

		for (int i = 0; i < DIR_ROWS_N; i++) begin
			row = DIR_ROWS[i];
			if (row.is_cfg) begin
				program_regs(row.tpu, row.tmo);
			end else begin
				slave_nak = row.cmd.sda;
				offer_tick(row.cmd, row.typed, row.want);
				while (bus_ph != BUS_IDLE) offer_tick(row.cmd, 1'b0, unused);
			end
		end

		for (int p = 0; p < RND_PHASES; p++) begin
			program_regs(RND_TPU[p], RND_TMO[p]);
			calm = (p == RND_PHASES - 1);
			// receiver stalls for a while so the block fills and pushes back
			if (p == 1) begin
				hold_req = 1'b1;
			end
			n = 0;
			while (n < RND_TICKS[p]) begin
				pick_tick(t);
				offer_tick(t, 1'b0, unused);
				n++;
			end
			op_plan_q.delete();
		end

		// Let the last command run out, then wait for every result
		while (bus_ph != BUS_IDLE) begin
			quiet_tick(t);
			offer_tick(t, 1'b0, unused);
		end
		push <= 1'b0;
		while (pin_snapshots_q.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);

		$display("Covered %0d ticks with %0d bus commands under %0d register settings,",
			tick_count, cmd_count, setting_count);
		$display("including %0d completed reads and %0d ACK timeouts.",
			read_count, timeout_count);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
